@@ hdl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_SAME(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/rpsc_pkg.sv @@
// shared constants and types for the rotating palette scan converter
package rpsc_pkg;

  localparam int FRAME_WIDTH_DEF  = 320;
  localparam int FRAME_HEIGHT_DEF = 240;

  localparam int BASE_LEVEL   = 190;
  localparam int BRIGHT_BOOST = 65;

  localparam int ENTRY_W     = 32;
  localparam int ADDR_IN_W   = 17;
  localparam int PIXEL_W     = 16;
  localparam int S_TDATA_W   = 56;
  localparam int M_TDATA_W   = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 1;

  // input tdata layout, lowest bit first
  localparam int ADDR_LSB  = 0;
  localparam int ENTRY_LSB = ADDR_LSB + ADDR_IN_W;

  // request kinds carried in tuser
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCAN_TRANSPOSED   = 8'd0,
    REG_MIRROR_HORIZONTAL = 8'd1,
    REG_MIRROR_VERTICAL   = 8'd2,
    REG_OVERLAY_ENABLE    = 8'd3
  } cfg_reg_t;

endpackage

@@ hdl/rpsc_ram.sv @@
// generic simple dual-port ram with registered read
module rpsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/rotating_palette_scan_converter.sv @@
// top level: frame store, scan address generator and palette to 5-6-5 conversion
//
//  channel  direction  handshake              payload
//  s_*      in         s_tvalid / s_tready    s_tuser request kind, s_tdata load pixel
//  m_*      out        m_tvalid / m_tready    m_tdata 5-6-5 pixel, m_tlast end of frame
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// one transaction per cycle in either direction while the output side keeps up
// a read passes the synchronous frame store read at the accepting edge, then the colour
// conversion into the output register once that register can advance
// in-range loads write the frame store at the accepting edge; loads give no output transaction
// rst clears the scan counters, the mode registers and all valid flags; the frame
// store is not cleared and needs no clearing pass
// when the output register is full and stalled, one read may wait on the ram
// output; after that s_tready drops until m_tready frees the output register
module rotating_palette_scan_converter
  import rpsc_pkg::*;
#(
  parameter int FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // req_type
  input  logic                   s_tuser,
  // pixel_addr[16:0], color_index[20:17], overlay_red[28:21], overlay_green[36:29],
  // overlay_blue[44:37], overlay_shift[48:45], zero fill[55:49]
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // pixel_565[15:0]
  output logic [M_TDATA_W-1:0]   m_tdata,
  // frame_last
  output logic                   m_tlast,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int CW    = $clog2(MAXD);
  localparam int LW    = $clog2(MAXD + 1);
  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);

  localparam logic [XW-1:0] X_MAX = XW'(FRAME_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(FRAME_HEIGHT - 1);
  localparam logic [LW-1:0] W_LEN = LW'(FRAME_WIDTH);
  localparam logic [LW-1:0] H_LEN = LW'(FRAME_HEIGHT);

  // mode registers
  logic scan_transposed;
  logic mirror_horizontal;
  logic mirror_vertical;
  logic overlay_enable;

  // scan position: outer is row in raster mode, column in transposed mode
  logic [CW-1:0] outer_cnt;
  logic [CW-1:0] inner_cnt;
  logic [LW-1:0] outer_len;
  logic [LW-1:0] inner_len;
  logic          inner_wrap;
  logic          outer_wrap;

  logic [XW-1:0] scan_x;
  logic [YW-1:0] scan_y;
  logic [AW-1:0] rd_addr;

  logic          cfg_acc;
  logic          cfg_mapped;
  logic          in_acc;
  logic          rd_acc;
  logic          ld_acc;
  logic          ld_in_range;

  // ram output stage and output register
  logic             s1_valid;
  logic             s1_last;
  logic [ENTRY_W-1:0] rd_entry;
  logic             advance;
  logic             out_valid;
  logic             out_last;
  logic [PIXEL_W-1:0] out_pixel;

  // palette expansion, optional overlay blend, 5-6-5 pack
  function automatic logic [PIXEL_W-1:0] to_rgb565(input logic [ENTRY_W-1:0] e,
                                                   input logic ovl);
    logic [7:0] lvl;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [3:0] sh;
    lvl = e[3] ? 8'(BASE_LEVEL + BRIGHT_BOOST) : 8'(BASE_LEVEL);
    b   = e[0] ? lvl : 8'd0;
    r   = e[1] ? lvl : 8'd0;
    g   = e[2] ? lvl : 8'd0;
    sh  = e[31:28];
    if (ovl) begin
      // shifts of eight and above clear the base colour; sums wrap at 8 bits
      r = (r >> sh) + e[11:4];
      g = (g >> sh) + e[19:12];
      b = (b >> sh) + e[27:20];
    end
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign cfg_mapped = cfg_acc && (cfg_index <= REG_OVERLAY_ENABLE);

  // a read may go to the ram unless the previous read result cannot move on
  assign advance  = !out_valid || m_tready;
  assign s_tready = !s1_valid || advance;
  assign in_acc   = s_tvalid && s_tready;
  assign rd_acc   = in_acc && (s_tuser == REQ_READ);
  assign ld_acc   = in_acc && (s_tuser == REQ_LOAD);

  assign ld_in_range = 32'(s_tdata[ADDR_LSB +: ADDR_IN_W]) < DEPTH;

  // scan geometry
  assign outer_len  = scan_transposed ? W_LEN : H_LEN;
  assign inner_len  = scan_transposed ? H_LEN : W_LEN;
  assign inner_wrap = LW'(inner_cnt) == inner_len - LW'(1);
  assign outer_wrap = LW'(outer_cnt) == outer_len - LW'(1);

  always_comb begin
    if (scan_transposed) begin
      scan_x = mirror_horizontal ? X_MAX - outer_cnt[XW-1:0] : outer_cnt[XW-1:0];
      scan_y = mirror_vertical   ? Y_MAX - inner_cnt[YW-1:0] : inner_cnt[YW-1:0];
    end else begin
      scan_x = inner_cnt[XW-1:0];
      scan_y = outer_cnt[YW-1:0];
    end
  end

  // raster address of the pixel due next
  assign rd_addr = AW'(scan_y * FRAME_WIDTH) + AW'(scan_x);

  // mode registers and scan counters
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_transposed   <= 1'b0;
      mirror_horizontal <= 1'b0;
      mirror_vertical   <= 1'b0;
      overlay_enable    <= 1'b0;
      outer_cnt         <= '0;
      inner_cnt         <= '0;
    end else if (cfg_acc) begin
      // any known register write restarts the frame
      case (cfg_index)
        REG_SCAN_TRANSPOSED: begin
          scan_transposed <= cfg_data[0];
          outer_cnt       <= '0;
          inner_cnt       <= '0;
        end
        REG_MIRROR_HORIZONTAL: begin
          mirror_horizontal <= cfg_data[0];
          outer_cnt         <= '0;
          inner_cnt         <= '0;
        end
        REG_MIRROR_VERTICAL: begin
          mirror_vertical <= cfg_data[0];
          outer_cnt       <= '0;
          inner_cnt       <= '0;
        end
        REG_OVERLAY_ENABLE: begin
          overlay_enable <= cfg_data[0];
          outer_cnt      <= '0;
          inner_cnt      <= '0;
        end
        default: begin
        end
      endcase
    end else if (rd_acc) begin
      if (inner_wrap) begin
        inner_cnt <= '0;
        outer_cnt <= outer_wrap ? '0 : outer_cnt + CW'(1);
      end else begin
        inner_cnt <= inner_cnt + CW'(1);
      end
    end
  end

  rpsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (ld_acc && ld_in_range),
    .wr_addr (AW'(s_tdata[ADDR_LSB +: ADDR_IN_W])),
    .wr_data (s_tdata[ENTRY_LSB +: ENTRY_W]),
    .rd_en   (rd_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // read pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_acc) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rd_acc) begin
      s1_last <= inner_wrap && outer_wrap;
    end
    if (advance && s1_valid) begin
      out_pixel <= to_rgb565(rd_entry, overlay_enable);
      out_last  <= s1_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pixel;
  assign m_tlast  = out_last;

`include "assert_macros.svh"

  // a waiting ram result is never overwritten by a new read
  `ASSERT_SAME(a_no_overrun, s1_valid && out_valid && !m_tready, !s_tready)
  // every accepted read reaches the ram output stage
  `ASSERT_NEXT(a_read_staged, rd_acc, s1_valid)
  // a known register write restarts the scan at the first pixel
  `ASSERT_NEXT(a_cfg_restart, cfg_mapped, outer_cnt == '0 && inner_cnt == '0)
  // scan counters stay inside the frame
  `ASSERT_SAME(a_cnt_range, 1'b1, LW'(inner_cnt) < inner_len && LW'(outer_cnt) < outer_len)

endmodule

@@ sim/tb_rotating_palette_scan_converter.sv @@
// self-checking testbench for the rotating palette scan converter
`timescale 1ns / 1ps

module tb_rotating_palette_scan_converter;
  import rpsc_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int FW             = FRAME_WIDTH_DEF;
  localparam int FH             = FRAME_HEIGHT_DEF;
  localparam int STORE_DEPTH    = FW * FH;
  localparam int ADDR_TOP       = (1 << ADDR_IN_W) - 1;
  localparam int SETTLE_CYCLES  = 4;     // wait after the last expected pixel before a register write
  localparam int TAIL_CYCLES    = 8;
  localparam int HOLD_CYCLES    = 400;   // long output stall to fill the pipeline
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MODE_SPAN      = 120;   // items between mode changes in the random part

  // an index outside the register map, writes to it change nothing
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

  // one stored pixel, laid out as in the upper part of s_tdata (index in the lowest bits)
  typedef struct packed {
    logic [3:0] shift;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [3:0] cidx;
  } store_entry_t;

  typedef struct packed {
    logic                 kind;
    logic [ADDR_IN_W-1:0] addr;
    store_entry_t         px;
  } pixel_req_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] rgb;
    logic               last;
  } pixel_result_t;

  typedef enum logic [1:0] {ROW_LOAD, ROW_READ, ROW_REG} row_kind_e;

  // directed row: for ROW_REG the addr field holds the register index and cidx[0] the value
  typedef struct packed {
    row_kind_e            kind;
    logic [ADDR_IN_W-1:0] addr;
    logic [3:0]           cidx;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [3:0]           shift;
    logic                 chk;
    logic [PIXEL_W-1:0]   rgb;
    logic                 last;
  } directed_row_t;

  localparam int N_DIRECTED = 30;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // fill the first six raster pixels and the first two pixels of the mirrored transposed scan
    '{ROW_LOAD, 0,                 15, 255, 255, 255,  0, 0, 0, 0},
    '{ROW_LOAD, 1,                  0,   0,   0,   0,  0, 0, 0, 0},
    '{ROW_LOAD, 2,                  7,   0,   0,   0,  0, 0, 0, 0},
    '{ROW_LOAD, 3,                  9, 128,   1, 255,  8, 0, 0, 0},
    '{ROW_LOAD, 4,                 10,  18,  52,  86, 15, 0, 0, 0},
    '{ROW_LOAD, 5,                  4, 255, 255, 255,  1, 0, 0, 0},
    '{ROW_LOAD, STORE_DEPTH - 1,   12, 127, 128,   1,  4, 0, 0, 0},
    '{ROW_LOAD, (FH - 2) * FW + FW - 1, 6, 200, 100, 50, 3, 0, 0, 0},
    // loads beyond the frame store are dropped
    '{ROW_LOAD, STORE_DEPTH,        3, 255, 255, 255,  0, 0, 0, 0},
    '{ROW_LOAD, ADDR_TOP,           5, 255, 255, 255, 15, 0, 0, 0},
    // plain palette straight after reset
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h0000, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hBDF7, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h001F, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hF800, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h05E0, 0},
    // overlay on: wrap of the channel sum, shift of 8 and shift of 15
    '{ROW_REG,  REG_OVERLAY_ENABLE, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h0000, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hBDF7, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h801F, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'h11AA, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 0},
    // mirrors alone leave raster order untouched
    '{ROW_REG,  REG_MIRROR_HORIZONTAL, 1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_REG,  REG_MIRROR_VERTICAL,   1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 1, 16'hFFFF, 0},
    // transposed and fully mirrored starts at the bottom right corner
    '{ROW_REG,  REG_SCAN_TRANSPOSED,   1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 0},
    // unmapped index must not restart the scan
    '{ROW_REG,  REG_UNMAPPED,          1, 0, 0, 0, 0, 0, 0, 0},
    '{ROW_READ, 0, 0, 0, 0, 0, 0, 0, 16'h0000, 0}
  };

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic                   s_tuser   = REQ_LOAD;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  always #CLK_HALF clk = ~clk;

  rotating_palette_scan_converter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // predictor state: own copy of the frame store, scan position and mode bits
  // ---------------------------------------------------------------------------
  store_entry_t  model_store [STORE_DEPTH];
  bit            written     [STORE_DEPTH];   // reads are only issued to written entries
  int unsigned   outer_pos, inner_pos;
  bit            md_transposed, md_mirror_h, md_mirror_v, md_overlay;
  pixel_result_t pixel_due_q [$];

  int unsigned items_sent, loads_taken, reads_taken, reg_writes;
  int unsigned pixels_checked, frames_seen, mismatches;

  // idle percentages, set by the stimulus and read by the driver and the receiver
  int unsigned src_idle_pct, sink_idle_pct;
  int unsigned hold_requests, hold_seen, hold_left;
  int unsigned stall_cycles;

  // raster address of the pixel the next read returns
  function automatic int unsigned scan_addr();
    int unsigned olen, ilen, o, i, x, y, a;
    olen = md_transposed ? FW : FH;
    ilen = md_transposed ? FH : FW;
    o = (outer_pos >= olen) ? 0 : outer_pos;
    i = (inner_pos >= ilen) ? 0 : inner_pos;
    if (md_transposed) begin
      x = md_mirror_h ? FW - 1 - o : o;
      y = md_mirror_v ? FH - 1 - i : i;
    end else begin
      x = i;
      y = o;
    end
    a = y * FW + x;
    return (a >= STORE_DEPTH) ? 0 : a;
  endfunction

  // move the scan on by one pixel, returns 1 on the last pixel of the frame
  function automatic logic step_scan();
    int unsigned olen, ilen;
    olen = md_transposed ? FW : FH;
    ilen = md_transposed ? FH : FW;
    if (outer_pos >= olen) outer_pos = 0;
    if (inner_pos >= ilen) inner_pos = 0;
    inner_pos++;
    if (inner_pos >= ilen) begin
      inner_pos = 0;
      outer_pos++;
      if (outer_pos >= olen) begin
        outer_pos = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // palette expansion, optional overlay blend with 8-bit wrap, then 5-6-5 packing
  function automatic logic [PIXEL_W-1:0] palette_to_565(input store_entry_t e);
    int unsigned level, ch_r, ch_g, ch_b;
    level = e.cidx[3] ? BASE_LEVEL + BRIGHT_BOOST : BASE_LEVEL;
    ch_b  = e.cidx[0] ? level : 0;
    ch_r  = e.cidx[1] ? level : 0;
    ch_g  = e.cidx[2] ? level : 0;
    if (md_overlay) begin
      ch_r = ((ch_r >> e.shift) + e.red)   & 8'hFF;
      ch_g = ((ch_g >> e.shift) + e.green) & 8'hFF;
      ch_b = ((ch_b >> e.shift) + e.blue)  & 8'hFF;
    end
    return {ch_r[7:3], ch_g[7:2], ch_b[7:3]};
  endfunction

  function automatic pixel_req_t random_req(input logic kind);
    pixel_req_t it;
    it.kind = kind;
    it.addr = ADDR_IN_W'($urandom);
    it.px   = store_entry_t'($urandom);
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // input side: offer one item, update the predictor at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic push_item(input pixel_req_t it, output pixel_result_t pred);
    int unsigned a;
    pred = '0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {{(S_TDATA_W - ENTRY_LSB - ENTRY_W){1'b0}}, it.px, it.addr};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (it.kind == REQ_LOAD) begin
      loads_taken++;
      if (it.addr < STORE_DEPTH) begin
        model_store[it.addr] = it.px;
        written[it.addr]     = 1'b1;
      end
    end else begin
      reads_taken++;
      a         = scan_addr();
      pred.last = step_scan();
      pred.rgb  = palette_to_565(model_store[a]);
    end
  endtask

  task automatic offer(input pixel_req_t it);
    pixel_result_t pred;
    push_item(it, pred);
    if (it.kind == REQ_READ) pixel_due_q.push_back(pred);
  endtask

  // read the next pixel, loading it first if it has never been written
  task automatic push_scan_read();
    pixel_req_t it;
    it      = random_req(REQ_LOAD);
    it.addr = ADDR_IN_W'(scan_addr());
    if (!written[it.addr]) offer(it);
    offer(random_req(REQ_READ));
  endtask

  task automatic push_random_load();
    pixel_req_t it;
    it = random_req(REQ_LOAD);
    case ($urandom_range(9))
      0:          it.addr = ADDR_IN_W'($urandom_range(ADDR_TOP, STORE_DEPTH));  // dropped
      1, 2, 3, 4: it.addr = ADDR_IN_W'(scan_addr());  // overwrite the pixel read next
      default:    it.addr = ADDR_IN_W'($urandom_range(STORE_DEPTH - 1));
    endcase
    offer(it);
  endtask

  // register write once the block has gone quiet
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
    logic mapped;
    s_tvalid <= 1'b0;
    while (pixel_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    mapped = 1'b1;
    case (idx)
      REG_SCAN_TRANSPOSED:   md_transposed = val;
      REG_MIRROR_HORIZONTAL: md_mirror_h   = val;
      REG_MIRROR_VERTICAL:   md_mirror_v   = val;
      REG_OVERLAY_ENABLE:    md_overlay    = val;
      default:               mapped        = 1'b0;
    endcase
    // any mapped write restarts the scan at the first pixel
    if (mapped) begin
      outer_pos = 0;
      inner_pos = 0;
    end
  endtask

  task automatic set_mode(input logic tr, input logic mh, input logic mv, input logic ov);
    write_reg(REG_SCAN_TRANSPOSED,   tr);
    write_reg(REG_MIRROR_HORIZONTAL, mh);
    write_reg(REG_MIRROR_VERTICAL,   mv);
    write_reg(REG_OVERLAY_ENABLE,    ov);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned target, next_mode;
    target    = items_sent + n_items;
    next_mode = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_mode) begin
        set_mode($urandom_range(1), $urandom_range(1), $urandom_range(1), $urandom_range(1));
        // now and then a write outside the register map
        if ($urandom_range(3) == 0)
          write_reg(CFG_INDEX_W'($urandom_range(REG_UNMAPPED, REG_OVERLAY_ENABLE + 1)),
                    $urandom_range(1));
        next_mode = items_sent + MODE_SPAN;
      end
      if ($urandom_range(99) < 60) push_scan_read();
      else push_random_load();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random back-pressure, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // output check: each transaction against the oldest expected pixel
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_pixels
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_due_q.size() == 0) begin
        $display("%0t: pixel expected none actual %h last %b", $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = pixel_due_q.pop_front();
        if (m_tdata !== want.rgb) begin
          $display("%0t: pixel_565 expected %h actual %h", $time, want.rgb, m_tdata);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: frame_last expected %b actual %b", $time, want.last, m_tlast);
          mismatches++;
        end
        pixels_checked++;
        if (m_tlast === 1'b1) frames_seen++;
      end
    end
  end

  // watchdog: cycles in a row with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    directed_row_t row;
    pixel_req_t    it;
    pixel_result_t pred;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles a little, receiver a lot
    src_idle_pct  = 29;
    sink_idle_pct = 79;

    // directed table, typed expectations where they are obvious
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_REG) begin
        write_reg(CFG_INDEX_W'(row.addr), row.cidx[0]);
      end else begin
        it.kind = (row.kind == ROW_READ) ? REQ_READ : REQ_LOAD;
        it.addr = row.addr;
        it.px   = {row.shift, row.blue, row.green, row.red, row.cidx};
        push_item(it, pred);
        if (row.kind == ROW_READ) begin
          if (row.chk) pixel_due_q.push_back(pixel_result_t'{rgb: row.rgb, last: row.last});
          else pixel_due_q.push_back(pred);
        end
      end
    end

    run_random(360);

    // now the other way round
    src_idle_pct  = 79;
    sink_idle_pct = 29;
    run_random(360);

    // no idling; first a long output stall while reads keep coming
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_requests++;
    repeat (40) push_scan_read();
    run_random(320);

    s_tvalid <= 1'b0;
    while (pixel_due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d reads and %0d register writes in raster and transposed order",
             loads_taken, reads_taken, reg_writes);
    $display("%0d pixels compared, %0d frame ends seen, %0d mismatches",
             pixels_checked, frames_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
